// ===== hw/rtl/bivk_pkg.sv =====
// shared types and codes for the block-indexed varint key lookup
package bivk_pkg;

  typedef enum logic [2:0] {
    CMD_BLOCK_KEY  = 3'd0,
    CMD_BLOCK_OFS  = 3'd1,
    CMD_KEY_BYTE   = 3'd2,
    CMD_DICT_WORD  = 3'd3,
    CMD_PACKED     = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NUM_BLOCKS   = 2'd0,
    REG_ENTRIES_PER  = 2'd1,
    REG_TOTAL        = 2'd2,
    REG_ID_BITS      = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_K0_RD,
    S_K0_CHK,
    S_BS_RD,
    S_BS_CHK,
    S_BLK_RD,
    S_BLK_CHK,
    S_D_RD,
    S_D_USE,
    S_ID_MUL,
    S_P_RD,
    S_P_USE,
    S_ID_EXT,
    S_DICT_USE,
    S_DONE
  } state_e;

  localparam int CfgWidth = 17;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [16:0] addr;
    logic [31:0] wdata;
    logic [31:0] query_key;
  } in_item_t;

  typedef struct packed {
    logic [23:0] value;
    logic        hit;
  } out_item_t;

  typedef struct packed {
    logic [10:0] num_blocks;
    logic [8:0]  entries_per_block;
    logic [16:0] total_entries;
    logic [4:0]  id_bits;
  } cfg_t;

endpackage

// ===== hw/rtl/bivk_ram.sv =====
// generic simple dual-port ram with registered read
module bivk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bivk_engine.sv =====
// index stores, packed-id clearing pass and the lookup sequencer
module bivk_engine #(
  parameter int MAX_BLOCKS   = 1024,
  parameter int DELTA_BYTES  = 65536,
  parameter int DICT_ENTRIES = 4096,
  parameter int PACKED_BYTES = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bivk_pkg::in_item_t  item_i,
  input  bivk_pkg::cfg_t      cfg_i,
  output logic                ready_o,
  output logic                res_valid_o,
  output bivk_pkg::out_item_t res_o,
  input  logic                res_take_i
);

  localparam int FAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DAW = (DELTA_BYTES > 1) ? $clog2(DELTA_BYTES) : 1;
  localparam int CAW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int PAW = (PACKED_BYTES > 1) ? $clog2(PACKED_BYTES) : 1;
  localparam int PW  = ($clog2(DELTA_BYTES) + 1 > 16) ? $clog2(DELTA_BYTES) + 1 : 17;
  localparam int PackedSpan = 5;

  bivk_pkg::state_e state_q, state_d;
  logic [PAW-1:0] clr_q, clr_d;

  logic [16:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0] key_q, key_d, cur_q, cur_d, acc_q, acc_d;
  logic [5:0]  sh_q, sh_d;
  logic [PW-1:0] pos_q, pos_d;
  logic        oob_q, oob_d;
  logic [24:0] idx0_q, idx0_d;
  logic [8:0]  cnt_q, cnt_d, i_q, i_d;
  logic [15:0] b_q, b_d;
  logic [16:0] idx_q, idx_d;
  logic [21:0] bitpos_q, bitpos_d;
  logic [2:0]  k_q, k_d;
  logic [39:0] buf_q, buf_d;
  logic [23:0] val_q, val_d;
  logic        hit_q, hit_d;

  logic [FAW-1:0] fk_raddr, fk_waddr;
  logic [31:0]    fk_rdata;
  logic           fk_we;
  logic [FAW-1:0] bs_raddr;
  logic [15:0]    bs_rdata;
  logic           bs_we;
  logic [DAW-1:0] dl_raddr;
  logic [7:0]     dl_rdata;
  logic           dl_we;
  logic [CAW-1:0] dc_raddr;
  logic [23:0]    dc_rdata;
  logic           dc_we;
  logic [PAW-1:0] pk_raddr, pk_waddr;
  logic [7:0]     pk_rdata, pk_wdata;
  logic           pk_we;

  logic [16:0] nb, mid;
  logic [7:0]  dbyte;
  logic [31:0] acc_n, sum, id, mask;
  logic [24:0] rem;
  logic [19:0] paddr;
  logic [39:0] shifted;

  // load beats go straight to their store
  always_comb begin
    fk_we = 1'b0;
    bs_we = 1'b0;
    dl_we = 1'b0;
    dc_we = 1'b0;
    pk_we = 1'b0;
    pk_waddr = clr_q;
    pk_wdata = 8'd0;
    fk_waddr = FAW'(item_i.addr);
    if (state_q == bivk_pkg::S_CLEAR) begin
      pk_we = 1'b1;
    end else if (start_i) begin
      unique case (item_i.cmd)
        bivk_pkg::CMD_BLOCK_KEY: fk_we = 32'(item_i.addr) < 32'(MAX_BLOCKS);
        bivk_pkg::CMD_BLOCK_OFS: bs_we = 32'(item_i.addr) < 32'(MAX_BLOCKS);
        bivk_pkg::CMD_KEY_BYTE:  dl_we = 32'(item_i.addr) < 32'(DELTA_BYTES);
        bivk_pkg::CMD_DICT_WORD: dc_we = 32'(item_i.addr) < 32'(DICT_ENTRIES);
        bivk_pkg::CMD_PACKED: begin
          pk_we    = 32'(item_i.addr) < 32'(PACKED_BYTES);
          pk_waddr = PAW'(item_i.addr);
          pk_wdata = item_i.wdata[7:0];
        end
        default: ;
      endcase
    end
  end

  bivk_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_first_keys (
    .clk_i, .we_i(fk_we), .waddr_i(fk_waddr), .wdata_i(item_i.wdata),
    .raddr_i(fk_raddr), .rdata_o(fk_rdata)
  );
  bivk_ram #(.WIDTH(16), .DEPTH(MAX_BLOCKS)) u_block_starts (
    .clk_i, .we_i(bs_we), .waddr_i(fk_waddr), .wdata_i(item_i.wdata[15:0]),
    .raddr_i(bs_raddr), .rdata_o(bs_rdata)
  );
  bivk_ram #(.WIDTH(8), .DEPTH(DELTA_BYTES)) u_delta_bytes (
    .clk_i, .we_i(dl_we), .waddr_i(DAW'(item_i.addr)), .wdata_i(item_i.wdata[7:0]),
    .raddr_i(dl_raddr), .rdata_o(dl_rdata)
  );
  bivk_ram #(.WIDTH(24), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk_i, .we_i(dc_we), .waddr_i(CAW'(item_i.addr)), .wdata_i(item_i.wdata[23:0]),
    .raddr_i(dc_raddr), .rdata_o(dc_rdata)
  );
  bivk_ram #(.WIDTH(8), .DEPTH(PACKED_BYTES)) u_packed (
    .clk_i, .we_i(pk_we), .waddr_i(pk_waddr), .wdata_i(pk_wdata),
    .raddr_i(pk_raddr), .rdata_o(pk_rdata)
  );

  always_comb begin
    nb = (32'(cfg_i.num_blocks) > 32'(MAX_BLOCKS)) ? 17'(MAX_BLOCKS)
                                                     : 17'(cfg_i.num_blocks);
    mid     = lo_q + ((hi_q - lo_q) >> 1);
    dbyte   = oob_q ? 8'd0 : dl_rdata;
    acc_n   = (sh_q < 6'd32) ? (acc_q | (32'(dbyte[6:0]) << sh_q[4:0])) : acc_q;
    sum     = cur_q + acc_n;
    rem     = 25'(cfg_i.total_entries) - idx0_q;
    paddr   = 20'(bitpos_q[21:3]) + 20'(k_q);
    shifted = buf_q >> bitpos_q[2:0];
    mask    = (32'd1 << cfg_i.id_bits) - 32'd1;
    id      = shifted[31:0] & mask;
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    key_d = key_q; cur_d = cur_q; acc_d = acc_q; sh_d = sh_q;
    pos_d = pos_q; oob_d = oob_q;
    idx0_d = idx0_q; cnt_d = cnt_q; i_d = i_q; b_d = b_q; idx_d = idx_q;
    bitpos_d = bitpos_q; k_d = k_q; buf_d = buf_q;
    val_d = val_q; hit_d = hit_q;
    fk_raddr = '0;
    bs_raddr = FAW'(b_q);
    dl_raddr = DAW'(pos_q);
    pk_raddr = PAW'(paddr);
    dc_raddr = CAW'(id);

    unique case (state_q)
      bivk_pkg::S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == PAW'(PACKED_BYTES - 1)) begin
          state_d = bivk_pkg::S_IDLE;
        end
      end
      bivk_pkg::S_IDLE: begin
        if (start_i && item_i.cmd == bivk_pkg::CMD_QUERY) begin
          key_d   = item_i.query_key;
          state_d = bivk_pkg::S_K0_RD;
        end
      end
      bivk_pkg::S_K0_RD: begin
        state_d = bivk_pkg::S_K0_CHK;
      end
      bivk_pkg::S_K0_CHK: begin
        val_d = '0;
        hit_d = 1'b0;
        if (nb == 17'd0 || key_q < fk_rdata) begin
          state_d = bivk_pkg::S_DONE;
        end else begin
          lo_d    = '0;
          hi_d    = nb;
          state_d = bivk_pkg::S_BS_RD;
        end
      end
      bivk_pkg::S_BS_RD: begin
        fk_raddr = FAW'(mid);
        mid_d    = mid;
        if (lo_q < hi_q) begin
          state_d = bivk_pkg::S_BS_CHK;
        end else if (lo_q == 17'd0) begin
          state_d = bivk_pkg::S_DONE;
        end else begin
          b_d     = 16'(lo_q - 17'd1);
          state_d = bivk_pkg::S_BLK_RD;
        end
      end
      bivk_pkg::S_BS_CHK: begin
        if (fk_rdata <= key_q) begin
          lo_d = mid_q + 17'd1;
        end else begin
          hi_d = mid_q;
        end
        state_d = bivk_pkg::S_BS_RD;
      end
      bivk_pkg::S_BLK_RD: begin
        fk_raddr = FAW'(b_q);
        idx0_d   = b_q * cfg_i.entries_per_block;
        state_d  = bivk_pkg::S_BLK_CHK;
      end
      bivk_pkg::S_BLK_CHK: begin
        cur_d = fk_rdata;
        pos_d = PW'(bs_rdata);
        acc_d = '0;
        sh_d  = '0;
        i_d   = '0;
        cnt_d = (rem > 25'(cfg_i.entries_per_block)) ? cfg_i.entries_per_block
                                                      : rem[8:0];
        if (idx0_q >= 25'(cfg_i.total_entries) || cfg_i.entries_per_block == 9'd0) begin
          state_d = bivk_pkg::S_DONE;
        end else begin
          state_d = bivk_pkg::S_D_RD;
        end
      end
      bivk_pkg::S_D_RD: begin
        // reads past the delta store end a varint
        oob_d = pos_q >= PW'(DELTA_BYTES);
        if (pos_q < PW'(DELTA_BYTES)) begin
          pos_d = pos_q + 1'b1;
        end
        state_d = bivk_pkg::S_D_USE;
      end
      bivk_pkg::S_D_USE: begin
        if (dbyte[7]) begin
          acc_d   = acc_n;
          sh_d    = (sh_q < 6'd32) ? sh_q + 6'd7 : sh_q;
          state_d = bivk_pkg::S_D_RD;
        end else if (sum >= key_q) begin
          if (sum == key_q) begin
            idx_d   = 17'(idx0_q + 25'(i_q));
            state_d = bivk_pkg::S_ID_MUL;
          end else begin
            state_d = bivk_pkg::S_DONE;
          end
        end else begin
          cur_d = sum;
          acc_d = '0;
          sh_d  = '0;
          i_d   = i_q + 9'd1;
          if (({1'b0, i_q} + 10'd1) == {1'b0, cnt_q}) begin
            state_d = bivk_pkg::S_DONE;
          end else begin
            state_d = bivk_pkg::S_D_RD;
          end
        end
      end
      bivk_pkg::S_ID_MUL: begin
        bitpos_d = idx_q * cfg_i.id_bits;
        k_d      = '0;
        state_d  = bivk_pkg::S_P_RD;
      end
      bivk_pkg::S_P_RD: begin
        oob_d   = 32'(paddr) >= 32'(PACKED_BYTES);
        k_d     = k_q + 3'd1;
        state_d = bivk_pkg::S_P_USE;
      end
      bivk_pkg::S_P_USE: begin
        // bytes shift in from the top, lowest address ends at the bottom
        buf_d = {(oob_q ? 8'd0 : pk_rdata), buf_q[39:8]};
        if (k_q == 3'(PackedSpan)) begin
          state_d = bivk_pkg::S_ID_EXT;
        end else begin
          state_d = bivk_pkg::S_P_RD;
        end
      end
      bivk_pkg::S_ID_EXT: begin
        hit_d = 1'b1;
        val_d = '0;
        if (id < 32'(DICT_ENTRIES)) begin
          state_d = bivk_pkg::S_DICT_USE;
        end else begin
          state_d = bivk_pkg::S_DONE;
        end
      end
      bivk_pkg::S_DICT_USE: begin
        val_d   = dc_rdata;
        state_d = bivk_pkg::S_DONE;
      end
      bivk_pkg::S_DONE: begin
        if (res_take_i) begin
          state_d = bivk_pkg::S_IDLE;
        end
      end
      default: state_d = bivk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bivk_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    key_q <= key_d; cur_q <= cur_d; acc_q <= acc_d; sh_q <= sh_d;
    pos_q <= pos_d; oob_q <= oob_d;
    idx0_q <= idx0_d; cnt_q <= cnt_d; i_q <= i_d; b_q <= b_d; idx_q <= idx_d;
    bitpos_q <= bitpos_d; k_q <= k_d; buf_q <= buf_d;
    val_q <= val_d; hit_q <= hit_d;
  end

  assign ready_o     = state_q == bivk_pkg::S_IDLE;
  assign res_valid_o = state_q == bivk_pkg::S_DONE;
  assign res_o.value = val_q;
  assign res_o.hit   = hit_q;

endmodule

// ===== hw/rtl/block_indexed_varint_key_lookup_top.sv =====
// Sorted-key index lookup over delta-varint keys.
// Input channel (in_valid_i / in_stall_o) takes load beats and query beats.
// A load beat writes one element of a store in the cycle it is accepted and
// gives no result; the block can take the next beat in the following cycle.
// A query beat reads the first block key, runs a binary search over the
// block keys, reads the block key and offset, then walks the delta bytes,
// and on a hit reads five packed-id bytes and, when the id lies inside the
// dictionary, one dictionary word.
// One query is in flight at a time; the result sits in an output register,
// so the next beat is taken while a result waits on out_stall_i.
// Configuration writes (cfg_we_i) are registered and are taken anytime.
// After reset the packed-id store is swept to zero, one byte a cycle, over
// all PACKED_BYTES bytes, with in_stall_o high; config writes still land.
module block_indexed_varint_key_lookup_top #(
  parameter int MAX_BLOCKS   = 1024,
  parameter int DELTA_BYTES  = 65536,
  parameter int DICT_ENTRIES = 4096,
  parameter int PACKED_BYTES = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bivk_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bivk_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bivk_pkg::CfgWidth-1:0] cfg_wdata_i
);

  bivk_pkg::cfg_t      cfg_q, cfg_d;
  bivk_pkg::out_item_t out_q, res;
  logic                out_valid_q, out_valid_d;
  logic                ready, res_valid, res_take, start;

  assign start    = in_valid_i && ready;
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bivk_pkg::reg_e'(cfg_idx_i))
        bivk_pkg::REG_NUM_BLOCKS:  cfg_d.num_blocks        = cfg_wdata_i[10:0];
        bivk_pkg::REG_ENTRIES_PER: cfg_d.entries_per_block = cfg_wdata_i[8:0];
        bivk_pkg::REG_TOTAL:       cfg_d.total_entries     = cfg_wdata_i[16:0];
        bivk_pkg::REG_ID_BITS:     cfg_d.id_bits           = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
    out_valid_d = res_take ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_blocks        <= 11'd0;
      cfg_q.entries_per_block <= 9'd64;
      cfg_q.total_entries     <= 17'd0;
      cfg_q.id_bits           <= 5'd8;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  bivk_engine #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .DELTA_BYTES(DELTA_BYTES),
    .DICT_ENTRIES(DICT_ENTRIES),
    .PACKED_BYTES(PACKED_BYTES)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .start_i(start),
    .item_i(in_data_i),
    .cfg_i(cfg_q),
    .ready_o(ready),
    .res_valid_o(res_valid),
    .res_o(res),
    .res_take_i(res_take)
  );

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/bivk_lookup_checker.sv =====
// scoreboard for the varint key index: mirrors the stores, predicts query results, compares
`timescale 1ns / 1ps
module bivk_lookup_checker
  import bivk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output int                  fail_count,
  output int                  pending
);

  localparam int NumBlk   = 1024;
  localparam int NumDelta = 65536;
  localparam int NumDict  = 4096;
  localparam int NumPack  = 131072;

  logic [31:0] blk_key_mem [NumBlk];
  logic [15:0] blk_ofs_mem [NumBlk];
  logic [7:0]  delta_mem   [NumDelta];
  logic [23:0] dict_mem    [NumDict];
  logic [7:0]  id_mem      [NumPack];

  logic [10:0] cfg_blocks;
  logic [8:0]  cfg_per_block;
  logic [16:0] cfg_total;
  logic [4:0]  cfg_id_width;

  out_item_t expected_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (blk_key_mem[i]) blk_key_mem[i] = '0;
    foreach (blk_ofs_mem[i]) blk_ofs_mem[i] = '0;
    foreach (delta_mem[i]) delta_mem[i] = '0;
    foreach (dict_mem[i]) dict_mem[i] = '0;
    foreach (id_mem[i]) id_mem[i] = '0;
  end

  function automatic logic [31:0] value_id(longint unsigned entry);
    longint unsigned bitpos, base, acc;
    int unsigned sh;
    acc = 0;
    if (cfg_id_width == 0) return 32'd0;
    bitpos = entry * cfg_id_width;
    base   = bitpos >> 3;
    sh     = bitpos & 7;
    for (int k = 0; k < 8; k++) begin
      if (base + k < NumPack) acc |= longint'(id_mem[base + k]) << (8 * k);
    end
    return 32'((acc >> sh) & ((64'd1 << cfg_id_width) - 1));
  endfunction

  function automatic out_item_t lookup(logic [31:0] key);
    int unsigned nb, lo, hi, mid, b, sh;
    logic [31:0] cur, acc, id;
    logic [7:0] d;
    longint unsigned idx0, cnt, pos;
    out_item_t r;
    r = '0;
    nb = (cfg_blocks > NumBlk) ? NumBlk : cfg_blocks;
    if (nb == 0 || key < blk_key_mem[0]) return r;
    lo = 0;
    hi = nb;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (blk_key_mem[mid] <= key) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return r;
    b    = lo - 1;
    cur  = blk_key_mem[b];
    idx0 = longint'(b) * cfg_per_block;
    if (idx0 >= cfg_total) return r;
    cnt = cfg_total - idx0;
    if (cnt > cfg_per_block) cnt = cfg_per_block;
    pos = blk_ofs_mem[b];
    for (longint unsigned i = 0; i < cnt; i++) begin
      acc = '0;
      sh  = 0;
      while (1) begin
        d = (pos < NumDelta) ? delta_mem[pos] : 8'd0;
        pos++;
        if (sh < 32) acc |= 32'(d[6:0]) << sh;
        if (!d[7]) break;
        sh += 7;
      end
      cur += acc;
      if (cur >= key) begin
        if (cur == key) begin
          id      = value_id(idx0 + i);
          r.value = (id < NumDict) ? dict_mem[id] : 24'd0;
          r.hit   = 1'b1;
        end
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg_blocks    <= '0;
      cfg_per_block <= 9'd64;
      cfg_total     <= '0;
      cfg_id_width  <= 5'd8;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_BLOCKS:  cfg_blocks    <= cfg_wdata_i[10:0];
          REG_ENTRIES_PER: cfg_per_block <= cfg_wdata_i[8:0];
          REG_TOTAL:       cfg_total     <= cfg_wdata_i[16:0];
          REG_ID_BITS:     cfg_id_width  <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.cmd)
          CMD_BLOCK_KEY:
            if (in_data_i.addr < NumBlk) blk_key_mem[in_data_i.addr] = in_data_i.wdata;
          CMD_BLOCK_OFS:
            if (in_data_i.addr < NumBlk) blk_ofs_mem[in_data_i.addr] = in_data_i.wdata[15:0];
          CMD_KEY_BYTE:
            if (in_data_i.addr < NumDelta) delta_mem[in_data_i.addr] = in_data_i.wdata[7:0];
          CMD_DICT_WORD:
            if (in_data_i.addr < NumDict) dict_mem[in_data_i.addr] = in_data_i.wdata[23:0];
          CMD_PACKED:
            id_mem[in_data_i.addr] = in_data_i.wdata[7:0];
          CMD_QUERY:
            expected_q.push_back(lookup(in_data_i.query_key));
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat value=%h hit=%b", out_data_i.value, out_data_i.hit);
        end else begin
          want = expected_q.pop_front();
          if (want.value !== out_data_i.value || want.hit !== out_data_i.hit) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected value=%h hit=%b, got value=%h hit=%b",
                       want.value, want.hit, out_data_i.value, out_data_i.hit);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_block_indexed_varint_key_lookup_top.sv =====
// stimulus and verdict for the block-indexed varint key lookup
`timescale 1ns / 1ps
module tb_block_indexed_varint_key_lookup_top;
  import bivk_pkg::*;

  localparam int IdleLimit = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [CfgWidth-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  int                  beats_sent;
  logic [31:0]         key_list[$];
  logic [31:0]         first_list[$];

  block_indexed_varint_key_lookup_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bivk_lookup_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // no-progress watchdog, also covers the packed-store sweep after reset
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_block_indexed_varint_key_lookup_top failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall = 1'b1;
      repeat (pick_gap()) @(negedge clk);
      out_stall = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  end

  // entered right after an accepting edge, leaves with the beat accepted
  task automatic send_beat(in_item_t it, bit counts);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (pick_gap()) @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    if (counts) beats_sent++;
  endtask

  task automatic load(cmd_e c, logic [16:0] a, logic [31:0] w);
    in_item_t it;
    it.cmd       = c;
    it.addr      = a;
    it.wdata     = w;
    it.query_key = $urandom();
    send_beat(it, 1'b1);
  endtask

  task automatic noise_beat();
    in_item_t it;
    it.addr      = $urandom();
    it.wdata     = $urandom();
    it.query_key = $urandom();
    case ($urandom_range(0, 4))
      0: it.cmd = 3'd6;
      1: it.cmd = 3'd7;
      2: begin
        it.cmd  = CMD_BLOCK_KEY;
        it.addr = $urandom_range(1024, 131071);
      end
      3: begin
        it.cmd  = CMD_KEY_BYTE;
        it.addr = $urandom_range(65536, 131071);
      end
      default: begin
        it.cmd  = ($urandom_range(0, 1) != 0) ? CMD_DICT_WORD : CMD_BLOCK_OFS;
        it.addr = (it.cmd == CMD_DICT_WORD) ? $urandom_range(4096, 131071)
                                             : $urandom_range(1024, 131071);
      end
    endcase
    send_beat(it, 1'b0);
  endtask

  task automatic query(logic [31:0] key);
    in_item_t it;
    it.cmd       = CMD_QUERY;
    it.addr      = $urandom();
    it.wdata     = $urandom();
    it.query_key = key;
    send_beat(it, 1'b1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(reg_e r, logic [CfgWidth-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = r;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'd0;
    if (r < 60) return $urandom_range(1, 127);
    if (r < 85) return $urandom_range(128, 16383);
    if (r < 95) return $urandom_range(16384, 32'h0fff_ffff);
    return $urandom();
  endfunction

  // writes one delta as a varint; the padded form carries junk above bit 31
  task automatic put_varint(logic [31:0] d, inout int pos);
    logic [7:0] b;
    logic [31:0] rest;
    if ($urandom_range(0, 19) == 0) begin
      for (int g = 0; g < 4; g++) begin
        load(CMD_KEY_BYTE, pos, {$urandom_range(0, 32'hffffff), 1'b1, d[7*g +: 7]});
        pos++;
      end
      load(CMD_KEY_BYTE, pos, {24'd0, 1'b1, 3'($urandom()), d[31:28]});
      pos++;
      repeat ($urandom_range(0, 2)) begin
        load(CMD_KEY_BYTE, pos, {24'd0, 1'b1, 7'($urandom())});
        pos++;
      end
      load(CMD_KEY_BYTE, pos, {24'd0, 1'b0, 7'($urandom())});
      pos++;
    end else begin
      rest = d;
      do begin
        b    = {1'b0, rest[6:0]};
        rest = rest >> 7;
        if (rest != 0) b[7] = 1'b1;
        load(CMD_KEY_BYTE, pos, {$urandom_range(0, 32'hffffff), b});
        pos++;
      end while (rest != 0);
    end
  endtask

  function automatic logic [31:0] pick_id(int idb);
    logic [31:0] id;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) id = $urandom_range(0, 15);
    else if (r < 9) id = $urandom_range(0, 4095);
    else id = $urandom();
    if (idb == 0) return 32'd0;
    if (idb < 32) id = id & ((32'd1 << idb) - 1);
    return id;
  endfunction

  // loads a consistent index so that every query reads only written entries
  task automatic load_index(int nb, int epb, int tot, int idb);
    logic [31:0] cur, d, id;
    logic [7:0]  pack_buf[int];
    bit          dict_done[int];
    longint      bp;
    int          pos, n, nent, nbytes;
    key_list.delete();
    first_list.delete();
    pos = $urandom_range(0, 4000);
    cur = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 5000);
    for (int b = 0; b < nb; b++) begin
      cur += (b == 0) ? 32'd0 : $urandom_range(1, 3000);
      first_list.push_back(cur);
      load(CMD_BLOCK_KEY, b, cur);
      n = tot - b * epb;
      if (n > epb) n = epb;
      if (n > 0) begin
        load(CMD_BLOCK_OFS, b, {$urandom_range(0, 16'hffff), 16'(pos)});
        for (int i = 0; i < n; i++) begin
          d = pick_delta();
          cur += d;
          key_list.push_back(cur);
          put_varint(d, pos);
        end
      end
    end
    nent = nb * epb;
    if (nent > tot) nent = tot;
    nbytes = (nent * idb + 7) / 8;
    for (int j = 0; j < nbytes; j++) pack_buf[j] = 8'd0;
    for (int e = 0; e < nent; e++) begin
      id = pick_id(idb);
      for (int j = 0; j < idb; j++) begin
        bp = longint'(e) * idb + j;
        if (id[j]) pack_buf[bp >> 3][bp & 7] = 1'b1;
      end
      if (id < 4096 && !dict_done.exists(id)) begin
        dict_done[id] = 1'b1;
        load(CMD_DICT_WORD, id, $urandom());
      end
    end
    for (int j = 0; j < nbytes; j++) load(CMD_PACKED, j, {$urandom_range(0, 32'hffffff), pack_buf[j]});
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (key_list.size() == 0 || r >= 85) begin
      case ($urandom_range(0, 3))
        0: return 32'd0;
        1: return 32'hffff_ffff;
        2: return (first_list.size() != 0) ? first_list[0] - 1 : $urandom();
        default: return $urandom();
      endcase
    end
    if (r >= 75 && first_list.size() != 0)
      return first_list[$urandom_range(0, first_list.size() - 1)];
    k = key_list[$urandom_range(0, key_list.size() - 1)];
    if (r < 45) return k;
    if (r < 60) return k + 1;
    return k - 1;
  endfunction

  task automatic run_phase(int nb, int epb, int tot, int idb, int nq);
    int nb_eff;
    wait_idle();
    write_reg(REG_NUM_BLOCKS, nb);
    write_reg(REG_ENTRIES_PER, epb);
    write_reg(REG_TOTAL, tot);
    write_reg(REG_ID_BITS, idb);
    nb_eff = (nb > 1024) ? 1024 : nb;
    load_index(nb_eff, epb, tot, idb);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 9) == 0) noise_beat();
      query(pick_key());
    end
  endtask

  initial begin
    int nb, epb, tot, idb;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    beats_sent = 0;
    repeat (6) @(posedge clk);
    rst_n = 1'b1;

    // empty index straight after reset
    query(32'd0);
    query(32'hffff_ffff);
    query($urandom());
    run_phase(3, 4, 12, 8, 12);
    run_phase(2, 0, 10, 5, 4);
    run_phase(2047, 1, 3, 16, 10);
    run_phase(1, 256, 131071, 16, 12);
    run_phase(4, 5, 20, 0, 8);
    run_phase(3, 6, 18, 31, 8);
    run_phase(2, 8, 16, 1, 8);
    run_phase(2, 4, 0, 8, 4);
    run_phase(0, 3, 5, 4, 3);

    beats_sent = 0;
    while (beats_sent < 850) begin
      nb  = $urandom_range(1, 8);
      epb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
      tot = nb * epb + $urandom_range(0, 6) - 3;
      if (tot < 0) tot = 0;
      idb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      run_phase(nb, epb, tot, idb, $urandom_range(10, 30));
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_block_indexed_varint_key_lookup_top passed");
    end else begin
      $display("tb_block_indexed_varint_key_lookup_top failed");
    end
    $finish;
  end

endmodule
